@@ rtl/wds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_pkg
// Shared types and constants of the windowed distance subsampler.
// ----------------------------------------------------------------------------
package wds_pkg;

    // default geometry
    localparam int WINDOW_DEPTH_DEF = 40;
    localparam int COORD_BITS_DEF   = 24;
    localparam int INDEX_BITS_DEF   = 16;

    // fixed field widths
    localparam int RADIUS_W    = 52;
    localparam int STEP_W      = 4;
    localparam int LIMIT_W     = 16;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = RADIUS_W;
    localparam int SQ_W        = 64;

    // register reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RST = '0;
    localparam logic [STEP_W-1:0]   STEP_RST   = STEP_W'(4);
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(65535);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RADIUS_SQUARED  = 2'd0,
        REG_DECIMATION_STEP = 2'd1,
        REG_POINT_LIMIT     = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_LOAD,
        ST_RUN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

endpackage

@@ rtl/wds_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wds_ram #(
    parameter int WIDTH  = 72,
    parameter int DEPTH  = 40,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/windowed_distance_subsampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_distance_subsampler
// Greedy Poisson-disk subsampling of a point stream against a ring of the
// most recently chosen points.
// ----------------------------------------------------------------------------
// Each point is one transaction; the block is busy until it has decided on it.
// Index 0 of a set is kept without a test. Any other index first runs a
// bit-serial remainder by the decimation step; an examined point then
// streams the window RAM through a single squarer, three axis products per
// stored point. A chosen index waits in the output register and the next
// point is accepted meanwhile; the decision of that next point stalls only if
// the output is still not taken.
// ----------------------------------------------------------------------------
module windowed_distance_subsampler #(
    parameter int WINDOW_DEPTH = wds_pkg::WINDOW_DEPTH_DEF,
    parameter int COORD_BITS   = wds_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS   = wds_pkg::INDEX_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wds_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wds_pkg::CFG_DATA_W-1:0]    cfg_data,
    // points in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_BITS-1:0]      s_coord_x,
    input  logic signed [COORD_BITS-1:0]      s_coord_y,
    input  logic signed [COORD_BITS-1:0]      s_coord_z,
    input  logic                              s_first_of_set,
    // chosen indices out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [wds_pkg::SAMPLE_W-1:0]      m_sample_index
);

    import wds_pkg::*;

    localparam int ADDR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CNT_W   = $clog2(INDEX_BITS);
    localparam int CMP_W   = ((INDEX_BITS > LIMIT_W) ? INDEX_BITS : LIMIT_W) + 1;
    localparam int IDXE_W  = (INDEX_BITS > SAMPLE_W) ? INDEX_BITS : SAMPLE_W;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int MUL_W   = (DIFF_W > 32) ? 32 : DIFF_W;
    localparam int RAM_W   = 3 * COORD_BITS;

    // configuration registers
    logic [RADIUS_W-1:0] radius_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // control
    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [ADDR_W-1:0]   slot_reg;
    logic [INDEX_BITS-1:0] point_counter_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [CNT_W-1:0]    bit_cnt_reg;
    logic [STEP_W-1:0]   rem_reg;
    logic [ADDR_W-1:0]   k_reg;
    axis_t               axis_reg;
    logic                chosen_reg;
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_index_reg;

    // point under test
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;

    // squared-distance pipeline
    logic                dv_reg, dlast_reg;
    logic [DIFF_W-1:0]   diff_abs_reg;
    logic                sv_reg, slast_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SQ_W-1:0]     acc_reg;

    // RAM
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [RAM_W-1:0]    ram_rdata;
    logic                push;

    // combinational helpers
    logic                s_accept;
    logic [INDEX_BITS-1:0] idx_in;
    logic [STEP_W-1:0]   step_eff;
    logic [STEP_W:0]     rem_shift;
    logic [STEP_W-1:0]   rem_next;
    logic                bound_ok;
    logic                mod_pass;
    logic                more;
    logic                issue;
    logic                out_free;
    logic signed [COORD_BITS-1:0] pt_c, win_c;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]   diff_abs;
    logic [MUL_W-1:0]    mul_a;
    logic [2*MUL_W-1:0]  prod;
    logic [SQ_W:0]       acc_sum;
    logic [SQ_W-1:0]     acc_total;
    logic [IDXE_W-1:0]   idx_ext;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign idx_in    = s_first_of_set ? '0 : point_counter_reg;
    assign step_eff  = (step_reg == '0) ? STEP_W'(1) : step_reg;

    // one bit of restoring remainder per cycle
    assign rem_shift = {rem_reg, idx_reg[bit_cnt_reg]};
    assign rem_next  = (rem_shift >= {1'b0, step_eff}) ?
                       STEP_W'(rem_shift - {1'b0, step_eff}) : rem_shift[STEP_W-1:0];
    assign bound_ok  = (CMP_W'(idx_reg) + CMP_W'(step_eff)) < CMP_W'(limit_reg);
    assign mod_pass  = (rem_next == '0) && bound_ok;

    assign more      = (FILL_W'(k_reg) + FILL_W'(1)) < fill_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (idx_in == '0) ? ST_DECIDE : ST_MOD;
                end
            end
            ST_MOD: begin
                if (bit_cnt_reg == '0) begin
                    if (!mod_pass) begin
                        state_next = ST_IDLE;
                    end else if (fill_reg == '0) begin
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (axis_reg == AXIS_Z && !more) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!dv_reg && !sv_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!chosen_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready   = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        issue     = 1'b0;
        push      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LOAD: begin
                ram_re = 1'b1;
            end
            ST_RUN: begin
                issue     = 1'b1;
                ram_re    = (axis_reg == AXIS_Z) && more;
                ram_raddr = k_reg + ADDR_W'(1);
            end
            ST_DECIDE: begin
                push = chosen_reg && out_free;
            end
            default: ;
        endcase
    end

    // axis select for the difference stage
    always_comb begin
        unique case (axis_reg)
            AXIS_X: begin
                pt_c  = px_reg;
                win_c = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
            end
            AXIS_Y: begin
                pt_c  = py_reg;
                win_c = ram_rdata[2*COORD_BITS-1:COORD_BITS];
            end
            default: begin
                pt_c  = pz_reg;
                win_c = ram_rdata[COORD_BITS-1:0];
            end
        endcase
    end

    assign diff     = DIFF_W'(pt_c) - DIFF_W'(win_c);
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign mul_a    = diff_abs_reg[MUL_W-1:0];
    assign prod     = mul_a * mul_a;

    assign acc_sum   = {1'b0, acc_reg} + {1'b0, sq_reg};
    assign acc_total = acc_sum[SQ_W] ? '1 : acc_sum[SQ_W-1:0];

    assign idx_ext   = IDXE_W'(idx_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            radius_reg        <= RADIUS_RST;
            step_reg          <= STEP_RST;
            limit_reg         <= LIMIT_RST;
            fill_reg          <= '0;
            slot_reg          <= '0;
            point_counter_reg <= '0;
            m_valid_reg       <= 1'b0;
            dv_reg            <= 1'b0;
            sv_reg            <= 1'b0;
        end else begin
            state_reg <= state_next;
            dv_reg    <= issue;
            sv_reg    <= dv_reg;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_RADIUS_SQUARED:  radius_reg <= cfg_data[RADIUS_W-1:0];
                    REG_DECIMATION_STEP: step_reg   <= cfg_data[STEP_W-1:0];
                    REG_POINT_LIMIT:     limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (s_accept) begin
                point_counter_reg <= (idx_in == '1) ? idx_in : idx_in + INDEX_BITS'(1);
                if (idx_in == '0) begin
                    fill_reg <= '0;
                    slot_reg <= '0;
                end
            end

            if (push) begin
                if (fill_reg < FILL_W'(WINDOW_DEPTH)) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                slot_reg    <= (slot_reg == ADDR_W'(WINDOW_DEPTH - 1)) ?
                               '0 : slot_reg + ADDR_W'(1);
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg      <= s_coord_x;
            py_reg      <= s_coord_y;
            pz_reg      <= s_coord_z;
            idx_reg     <= idx_in;
            rem_reg     <= '0;
            bit_cnt_reg <= CNT_W'(INDEX_BITS - 1);
            chosen_reg  <= 1'b1;
        end

        if (state_reg == ST_MOD) begin
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg - CNT_W'(1);
            if (bit_cnt_reg == '0) begin
                chosen_reg <= mod_pass;
            end
        end

        if (state_reg == ST_LOAD) begin
            k_reg    <= '0;
            axis_reg <= AXIS_X;
            acc_reg  <= '0;
        end

        if (issue) begin
            unique case (axis_reg)
                AXIS_X:  axis_reg <= AXIS_Y;
                AXIS_Y:  axis_reg <= AXIS_Z;
                default: begin
                    axis_reg <= AXIS_X;
                    k_reg    <= k_reg + ADDR_W'(1);
                end
            endcase
        end

        // difference stage
        diff_abs_reg <= diff_abs;
        dlast_reg    <= (axis_reg == AXIS_Z);

        // square stage, saturates when the difference needs more than 32 bits
        sq_reg    <= ((diff_abs_reg >> MUL_W) != '0) ? '1 : SQ_W'(prod);
        slast_reg <= dlast_reg;

        // accumulate and test one window entry
        if (sv_reg) begin
            if (slast_reg) begin
                acc_reg <= '0;
                if (acc_total < SQ_W'(radius_reg)) begin
                    chosen_reg <= 1'b0;
                end
            end else begin
                acc_reg <= acc_total;
            end
        end

        if (push) begin
            m_index_reg <= idx_ext[SAMPLE_W-1:0];
        end
    end

    wds_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_window_ram (
        .aclk (aclk),
        .we   (push),
        .waddr(slot_reg),
        .wdata({px_reg, py_reg, pz_reg}),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign m_valid        = m_valid_reg;
    assign m_sample_index = m_index_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW_DEPTH))
        else $error("window fill exceeds depth");

    a_read_valid_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (FILL_W'(k_reg) < fill_reg))
        else $error("window read beyond filled entries");

    a_decide_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> (!dv_reg && !sv_reg))
        else $error("decision taken with distance pipeline busy");

    a_out_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("result raised outside decision");

    a_new_set_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_first_of_set) |=>
            (fill_reg == '0 && state_reg == ST_DECIDE))
        else $error("new set did not clear the window");

endmodule

@@ tb/tb_windowed_distance_subsampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_distance_subsampler
// Self-checking bench for the windowed distance subsampler. A clocked driver
// feeds points from a queue and a clocked monitor predicts each chosen index
// from its own copy of the window ring, then checks the result stream in
// order. Directed scans cover extreme coordinates, the radius boundary, new
// sets, zero step and tight limits; random clustered scans follow under
// several register settings.
// ----------------------------------------------------------------------------
module tb_windowed_distance_subsampler;
    import wds_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RING_DEPTH     = WINDOW_DEPTH_DEF;
    localparam int          DRAIN_CYCLES   = 200;
    localparam longint      CYCLE_LIMIT    = 8_000_000;
    localparam int          MAX_REPORTS    = 40;
    localparam int          RAND_PHASES    = 8;
    localparam int          PHASE_ITEMS    = 112;
    localparam logic [1:0]  REG_UNMAPPED   = 2'd3;

    typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

    localparam coord_t              COORD_MAX  = {1'b0, {(COORD_BITS_DEF-1){1'b1}}};
    localparam coord_t              COORD_MIN  = {1'b1, {(COORD_BITS_DEF-1){1'b0}}};
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   first;
    } point_t;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    coord_t                 s_coord_x      = '0;
    coord_t                 s_coord_y      = '0;
    coord_t                 s_coord_z      = '0;
    logic                   s_first_of_set = 1'b0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [SAMPLE_W-1:0]    m_sample_index;

    windowed_distance_subsampler dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_coord_x      (s_coord_x),
        .s_coord_y      (s_coord_y),
        .s_coord_z      (s_coord_z),
        .s_first_of_set (s_first_of_set),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_index (m_sample_index)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Subsampler prediction state
    // ------------------------------------------------------------------
    logic [RADIUS_W-1:0] cfg_radius = RADIUS_RST;
    logic [STEP_W-1:0]   cfg_step   = STEP_RST;
    logic [LIMIT_W-1:0]  cfg_limit  = LIMIT_RST;
    coord_t              ring_x [RING_DEPTH];
    coord_t              ring_y [RING_DEPTH];
    coord_t              ring_z [RING_DEPTH];
    int                  ring_fill  = 0;
    int                  ring_slot  = 0;
    logic [SAMPLE_W-1:0] point_idx  = '0;

    logic [SAMPLE_W-1:0] expected_samples [$];
    point_t              point_queue [$];
    point_t              drv_point;
    logic [SAMPLE_W-1:0] want_idx;
    logic [SAMPLE_W-1:0] chosen_idx;
    logic                point_fire  = 1'b0;
    bit                  idle_on     = 1'b1;
    int                  send_gap    = 0;
    int                  recv_stall  = 0;
    int                  error_count = 0;
    longint              cycle_count = 0;

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_RADIUS_SQUARED:  cfg_radius = value[RADIUS_W-1:0];
            REG_DECIMATION_STEP: cfg_step   = value[STEP_W-1:0];
            REG_POINT_LIMIT:     cfg_limit  = value[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    // Decides one point; returns 1 and its index when it is chosen.
    function automatic bit choose_point(input coord_t x, input coord_t y, input coord_t z,
                                        input logic first, output logic [SAMPLE_W-1:0] idx);
        int                eff_step;
        bit                keep;
        longint            dx;
        longint            dy;
        longint            dz;
        longint unsigned   sq_dist;

        keep     = 1'b0;
        eff_step = (cfg_step == 0) ? 1 : int'(cfg_step);
        if (first)
            point_idx = '0;
        idx = point_idx;
        if (point_idx == 0) begin
            ring_fill = 0;
            ring_slot = 0;
            keep      = 1'b1;
        end else if (int'(point_idx) % eff_step == 0 &&
                     int'(point_idx) + eff_step < int'(cfg_limit)) begin
            keep = 1'b1;
            for (int k = 0; k < ring_fill; k++) begin
                dx      = longint'(x) - longint'(ring_x[k]);
                dy      = longint'(y) - longint'(ring_y[k]);
                dz      = longint'(z) - longint'(ring_z[k]);
                sq_dist = dx * dx + dy * dy + dz * dz;
                if (sq_dist < {12'b0, cfg_radius})
                    keep = 1'b0;
            end
        end
        // counter holds at its top value until the next set
        if (point_idx != '1)
            point_idx++;
        if (keep) begin
            ring_x[ring_slot] = x;
            ring_y[ring_slot] = y;
            ring_z[ring_slot] = z;
            ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
            if (ring_fill < RING_DEPTH)
                ring_fill++;
        end
        return keep;
    endfunction

    // ------------------------------------------------------------------
    // Point driver and result-side backpressure
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || point_fire) begin
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap--;
            end else if (point_queue.size() != 0) begin
                drv_point = point_queue.pop_front();
                s_coord_x      <= drv_point.x;
                s_coord_y      <= drv_point.y;
                s_coord_z      <= drv_point.z;
                s_first_of_set <= drv_point.first;
                s_valid        <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 19);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            m_ready <= 1'b0;
            recv_stall--;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 9) == 0)
                recv_stall = $urandom_range(1, 19);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: register writes, accepted points, chosen indices
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            point_fire <= 1'b0;
        end else begin
            point_fire <= s_valid && s_ready;
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                if (choose_point(s_coord_x, s_coord_y, s_coord_z, s_first_of_set, chosen_idx))
                    expected_samples.insert(expected_samples.size(), chosen_idx);
            end
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("sample_index %0d with none expected",
                                              m_sample_index));
                end else begin
                    want_idx = expected_samples.pop_front();
                    if (m_sample_index !== want_idx)
                        report_mismatch($sformatf("sample_index got %0d expected %0d",
                                                  m_sample_index, want_idx));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("windowed_distance_subsampler: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [RADIUS_W-1:0] radius,
                                input logic [STEP_W-1:0] step,
                                input logic [LIMIT_W-1:0] limit);
        write_reg(REG_RADIUS_SQUARED, CFG_DATA_W'(radius));
        write_reg(REG_DECIMATION_STEP, CFG_DATA_W'(step));
        write_reg(REG_POINT_LIMIT, CFG_DATA_W'(limit));
    endtask

    // Sender holds off until every chosen index is out and the block has settled.
    task automatic wait_quiet();
        do @(posedge aclk);
        while (point_queue.size() != 0 || s_valid || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_point(input coord_t x, input coord_t y, input coord_t z,
                               input logic first);
        point_t p;
        p.x     = x;
        p.y     = y;
        p.z     = z;
        p.first = first;
        point_queue.insert(point_queue.size(), p);
    endtask

    function automatic coord_t near_coord(input coord_t center, input int spread);
        return coord_t'(int'(center) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    initial begin
        int                  spread;
        int                  set_len;
        int                  queued;
        bit                  opens_set;
        coord_t              cx;
        coord_t              cy;
        coord_t              cz;
        logic [RADIUS_W-1:0] radius;
        logic [STEP_W-1:0]   step;
        logic [LIMIT_W-1:0]  limit;
        longint unsigned     span;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: index 0 without a set marker, then one examined point
        queue_point('0, '0, '0, 1'b0);
        repeat (4) queue_point(COORD_MAX, '0, COORD_MIN, 1'b0);
        wait_quiet();

        // Radius boundary with extreme coordinates; zero step acts as one
        program_regs(RADIUS_W'(900), '0, LIMIT_RST);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);              // duplicate
        queue_point(coord_t'(COORD_MIN + 30), COORD_MIN, COORD_MIN, 1'b0); // exactly r^2
        queue_point(coord_t'(COORD_MIN + 59), coord_t'(COORD_MIN + 7),
                    coord_t'(COORD_MIN + 3), 1'b0);                      // just inside
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);              // new set mid-scan
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        wait_quiet();

        // Full radius and a limit equal to the step: only index 0 survives
        program_regs(RADIUS_MAX, STEP_W'(3), LIMIT_W'(3));
        queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
        repeat (5) queue_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                               1'b0);
        wait_quiet();

        // Random clustered scans, one register setting per phase
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_on = (ph != RAND_PHASES - 1);
            spread  = 1 << $urandom_range(1, 22);
            span    = 3 * longint'(spread) * longint'(spread) + 1;
            case (ph)
                0:       radius = RADIUS_MAX;
                5:       radius = '0;
                default: radius = RADIUS_W'({$urandom, $urandom} % span);
            endcase
            case (ph)
                1:       step = STEP_W'(15);
                2:       step = '0;
                3:       step = STEP_W'(1);
                default: step = STEP_W'($urandom_range(1, 15));
            endcase
            case (ph)
                4:       limit = LIMIT_W'($urandom_range(0, 20));
                6:       limit = LIMIT_W'($urandom_range(40, 160));
                default: limit = ($urandom_range(0, 1) == 0) ? LIMIT_RST
                                 : LIMIT_W'($urandom_range(200, 65535));
            endcase
            if (ph == 3)
                write_reg(REG_UNMAPPED, CFG_DATA_W'({$urandom, $urandom}));
            program_regs(radius, step, limit);

            queued = 0;
            while (queued < PHASE_ITEMS) begin
                set_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                        : $urandom_range(1, 40);
                if (set_len > PHASE_ITEMS - queued)
                    set_len = PHASE_ITEMS - queued;
                opens_set = ($urandom_range(0, 7) != 0);
                cx        = coord_t'($urandom);
                cy        = coord_t'($urandom);
                cz        = coord_t'($urandom);
                for (int n = 0; n < set_len; n++) begin
                    // mostly near the cluster center, now and then a stray point
                    if ($urandom_range(0, 9) == 0)
                        queue_point(coord_t'($urandom), coord_t'($urandom),
                                    coord_t'($urandom), (n == 0) && opens_set);
                    else
                        queue_point(near_coord(cx, spread), near_coord(cy, spread),
                                    near_coord(cz, spread), (n == 0) && opens_set);
                end
                queued += set_len;
            end
            wait_quiet();
        end

        if (error_count == 0)
            $display("windowed_distance_subsampler: match");
        else
            $display("windowed_distance_subsampler: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/wds_pkg.sv
rtl/wds_ram.sv
rtl/windowed_distance_subsampler.sv
tb/tb_windowed_distance_subsampler.sv
